// ----- design/ges_pkg.sv -----
// Shared types, constants and fixed-point helpers for the Gaussian elimination solver.
// No dependencies; every other design file refers to this package by scoped names.
package ges_pkg;

	localparam int MAX_UNKNOWNS = 8;
	localparam int DATA_W = 48;
	localparam int FRAC_W = 24;

	localparam int MAX_COLS = MAX_UNKNOWNS + 1;
	localparam int CELLS = MAX_UNKNOWNS * MAX_COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SOL_AW = $clog2(MAX_UNKNOWNS);
	localparam int ROW_W = $clog2(MAX_UNKNOWNS + 1);
	localparam int COL_W = $clog2(MAX_COLS + 1);
	localparam int CNT_LD_W = $clog2(CELLS + 1);

	// quotient bits and multiplier half width
	localparam int QUO_W = DATA_W + FRAC_W;
	localparam int HALF_W = (DATA_W + 1) / 2;
	localparam int PROD_W = 4 * HALF_W;
	localparam int WIDE_W = (QUO_W > PROD_W) ? QUO_W : PROD_W;

	// register and field widths
	localparam int UNK_W = 4;
	localparam int COLS_W = 4;
	localparam int THR_W = 25;
	localparam int INDEX_W = 3;
	localparam int STATUS_W = 2;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_UNKNOWNS  = 2'd0,
		REG_COLUMNS   = 2'd1,
		REG_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_SHAPE    = 2'd1,
		STATUS_SINGULAR = 2'd2
	} status_t;

	typedef enum logic {
		ALU_MUL = 1'b0,
		ALU_DIV = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] result;
	} alu_rsp_t;

	function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
		logic [DATA_W-1:0] u;
		u = v;
		return v[DATA_W-1] ? (~u + 1'b1) : u;
	endfunction

	// apply sign to a wide magnitude, saturating to the signed data range
	function automatic logic signed [DATA_W-1:0] from_mag(input logic neg,
			input logic [WIDE_W-1:0] m);
		logic [WIDE_W-1:0] lim;
		logic [DATA_W-1:0] r;
		lim = WIDE_W'(1) << (DATA_W - 1);
		if (!neg) lim = lim - 1'b1;
		r = (m > lim) ? lim[DATA_W-1:0] : m[DATA_W-1:0];
		return neg ? (~r + 1'b1) : r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		logic [DATA_W:0] d;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] != d[DATA_W-1])
			return d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		return d[DATA_W-1:0];
	endfunction

endpackage

// ----- design/ges_element_if.sv -----
// Input channel: one matrix element per transaction.
// Depends on ges_pkg for the data width.
interface ges_element_if;
	logic                              valid;
	logic                              ready;
	logic signed [ges_pkg::DATA_W-1:0] element;

	modport source (output valid, output element, input ready);
	modport sink (input valid, input element, output ready);
endinterface

// ----- design/ges_result_if.sv -----
// Output channel: one solution value or one status per transaction.
// Depends on ges_pkg for field widths.
interface ges_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [ges_pkg::DATA_W-1:0]   value;
	logic        [ges_pkg::INDEX_W-1:0]  index;
	logic        [ges_pkg::STATUS_W-1:0] status;
	logic                                last;

	modport source (output valid, output value, output index, output status, output last,
		input ready);
	modport sink (input valid, input value, input index, input status, input last,
		output ready);
endinterface

// ----- design/ges_alu.sv -----
// Shared multi-cycle fixed-point multiplier (four half-width partial products)
// and restoring divider (one quotient bit per cycle). Depends on ges_pkg.
module ges_alu (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ges_pkg::alu_req_t                 req,
	input  logic signed [ges_pkg::DATA_W-1:0] a,
	input  logic signed [ges_pkg::DATA_W-1:0] b,
	output ges_pkg::alu_rsp_t                 rsp
);
	localparam int DW = ges_pkg::DATA_W;
	localparam int QW = ges_pkg::QUO_W;
	localparam int HW = ges_pkg::HALF_W;
	localparam int PW = ges_pkg::PROD_W;
	localparam int WW = ges_pkg::WIDE_W;
	localparam int CNT_W = $clog2(QW + 1);

	logic                 busy_q;
	logic                 done_q;
	ges_pkg::alu_op_t     op_q;
	logic                 neg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [QW-1:0]        num_q;
	logic [QW-1:0]        quo_q;
	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        d_q;
	logic [2*HW-1:0]      x_q;
	logic [2*HW-1:0]      y_q;
	logic [PW-1:0]        acc_q;
	logic signed [DW-1:0] res_q;

	logic [DW:0]     rem2;
	logic            ge;
	logic [DW:0]     rem_nx;
	logic [1:0]      idx;
	logic [HW-1:0]   xs;
	logic [HW-1:0]   ys;
	logic [2*HW-1:0] part;
	logic [PW-1:0]   part_sh;
	logic [DW-1:0]   ma;
	logic [DW-1:0]   mb;

	always_comb begin
		ma = ges_pkg::mag(a);
		mb = ges_pkg::mag(b);
		rem2 = {rem_q, num_q[QW-1]};
		ge = rem2 >= {1'b0, d_q};
		rem_nx = ge ? rem2 - {1'b0, d_q} : rem2;
		idx = 2'(cnt_q - 1'b1);
		xs = idx[0] ? x_q[2*HW-1:HW] : x_q[HW-1:0];
		ys = idx[1] ? y_q[2*HW-1:HW] : y_q[HW-1:0];
		part = xs * ys;
		part_sh = (PW'(part) << (idx[0] ? HW : 0)) << (idx[1] ? HW : 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				op_q <= req.op;
				neg_q <= a[DW-1] ^ b[DW-1];
				if (req.op == ges_pkg::ALU_DIV) begin
					if (mb == '0) begin
						// zero divisor: saturate toward the dividend's sign, 0/0 is 0
						res_q <= ges_pkg::from_mag(a[DW-1], (ma != '0) ? {WW{1'b1}} : '0);
						done_q <= 1'b1;
					end else begin
						busy_q <= 1'b1;
						num_q <= {ma, {ges_pkg::FRAC_W{1'b0}}};
						rem_q <= '0;
						quo_q <= '0;
						d_q <= mb;
						cnt_q <= CNT_W'(QW);
					end
				end else begin
					busy_q <= 1'b1;
					x_q <= (2*HW)'(ma);
					y_q <= (2*HW)'(mb);
					acc_q <= '0;
					cnt_q <= CNT_W'(4);
				end
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
					if (op_q == ges_pkg::ALU_DIV) begin
						rem_q <= rem_nx[DW-1:0];
						num_q <= {num_q[QW-2:0], 1'b0};
						quo_q <= {quo_q[QW-2:0], ge};
					end else begin
						acc_q <= acc_q + part_sh;
					end
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					if (op_q == ges_pkg::ALU_DIV)
						res_q <= ges_pkg::from_mag(neg_q, WW'(quo_q));
					else
						res_q <= ges_pkg::from_mag(neg_q, WW'(acc_q >> ges_pkg::FRAC_W));
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.result = res_q;

endmodule

// ----- design/gaussian_elimination_solver_top.sv -----
// Gaussian elimination solver with partial pivoting, signed Q24.24 in 48 bits.
// Depends on ges_pkg, ges_element_if, ges_result_if and ges_alu.
//
// The augmented matrix is loaded row-major, one element per cycle, into a
// simple dual-port matrix memory (one read, one write per cycle, registered read).
// The element that completes unknowns*columns starts the solve; no input is
// taken until the run's last result transaction is done. The solve is a
// sequencer around that memory and one shared ALU. Per pivot column it reads
// every candidate row, swaps the chosen row with the pivot row column by
// column when they differ, and for each row below it does one divide plus one
// multiply per remaining column. Back substitution costs one multiply per
// off-diagonal term and one divide per unknown. Results leave one at a time.
// The memories need no clearing pass after reset.
// A shape mismatch or a pivot magnitude below singular_threshold gives one
// status transaction with last set instead of the solution.
module gaussian_elimination_solver_top (
	input  logic                               clk,
	input  logic                               arst_n,
	ges_element_if.sink                        element_ch,
	ges_result_if.source                       result_ch,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ges_pkg::PADDR_W-1:0]        paddr,
	input  logic [ges_pkg::PDATA_W-1:0]        pwdata,
	output logic [ges_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);
	localparam int DW = ges_pkg::DATA_W;
	localparam int AW = ges_pkg::ADDR_W;
	localparam int SW = ges_pkg::SOL_AW;
	localparam int RW = ges_pkg::ROW_W;
	localparam int CW = ges_pkg::COL_W;
	localparam int LW = ges_pkg::CNT_LD_W;

	typedef enum logic [4:0] {
		LOAD, CHECK, PIV_START, PIV_RD, PIV_CMP, PIV_DONE,
		SW_RD_A, SW_RD_B, SW_WR_A, SW_WR_B,
		EL_START, EL_RD_F, EL_DIV_START, EL_DIV_WAIT,
		EL_RD_I, EL_RD_J, EL_MUL, EL_MUL_WAIT, NEXT_I,
		BS_RD_S, BS_CAP_S, BS_RD_J, BS_MUL, BS_MUL_WAIT,
		BS_RD_D, BS_DIV, BS_DIV_WAIT,
		EM_RD, EM_CAP, EM_WAIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [ges_pkg::UNK_W-1:0]  unk_q;
	logic [ges_pkg::COLS_W-1:0] col_q;
	logic [ges_pkg::THR_W-1:0]  thr_q;

	logic [RW-1:0] u_cl;
	logic [CW-1:0] c_cl;
	logic [LW-1:0] total;

	// sequencer counters and operands
	logic [LW-1:0]        lc_q;
	logic [RW-1:0]        i_q, j_q, best_q, e_q;
	logic [CW-1:0]        k_q;
	logic [DW-1:0]        bm_q;
	logic signed [DW-1:0] piv_q, tmp_q, f_q, aik_q, ajk_q, s_q;

	// result register
	logic                         out_valid_q;
	logic signed [DW-1:0]         out_value_q;
	logic [ges_pkg::INDEX_W-1:0]  out_index_q;
	ges_pkg::status_t             out_status_q;
	logic                         out_last_q;

	// memories
	logic signed [DW-1:0] mat_mem [ges_pkg::CELLS];
	logic signed [DW-1:0] sol_mem [ges_pkg::MAX_UNKNOWNS];
	logic                 m_we, m_re, s_we, s_re;
	logic [AW-1:0]        m_waddr, m_raddr;
	logic [SW-1:0]        s_waddr, s_raddr;
	logic signed [DW-1:0] m_wdata, s_wdata;
	logic signed [DW-1:0] mrd_q, srd_q;

	ges_pkg::alu_req_t    alu_req;
	ges_pkg::alu_rsp_t    alu_rsp;
	logic signed [DW-1:0] alu_a, alu_b;

	logic in_acc, out_acc, cfg_wr;
	logic [DW-1:0] mrd_mag;

	function automatic logic [AW-1:0] addr(input logic [RW-1:0] row, input logic [CW-1:0] col,
			input logic [CW-1:0] ncol);
		return AW'(row) * AW'(ncol) + AW'(col);
	endfunction

	// clamp configuration to the supported shape
	always_comb begin
		if (unk_q == '0) u_cl = RW'(1);
		else if (unk_q > ges_pkg::UNK_W'(ges_pkg::MAX_UNKNOWNS))
			u_cl = RW'(ges_pkg::MAX_UNKNOWNS);
		else u_cl = RW'(unk_q);
		if (col_q == '0) c_cl = CW'(1);
		else if (col_q > ges_pkg::COLS_W'(ges_pkg::MAX_COLS)) c_cl = CW'(ges_pkg::MAX_COLS);
		else c_cl = CW'(col_q);
		total = LW'(u_cl) * LW'(c_cl);
	end

	assign in_acc = element_ch.valid && element_ch.ready;
	assign out_acc = result_ch.valid && result_ch.ready;
	assign element_ch.ready = (state_q == LOAD);
	assign mrd_mag = ges_pkg::mag(mrd_q);

	// APB register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unk_q <= ges_pkg::UNK_W'(8);
			col_q <= ges_pkg::COLS_W'(9);
			thr_q <= ges_pkg::THR_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				ges_pkg::REG_UNKNOWNS:  unk_q <= pwdata[ges_pkg::UNK_W-1:0];
				ges_pkg::REG_COLUMNS:   col_q <= pwdata[ges_pkg::COLS_W-1:0];
				ges_pkg::REG_THRESHOLD: thr_q <= pwdata[ges_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ges_pkg::REG_UNKNOWNS:  prdata = ges_pkg::PDATA_W'(unk_q);
			ges_pkg::REG_COLUMNS:   prdata = ges_pkg::PDATA_W'(col_q);
			ges_pkg::REG_THRESHOLD: prdata = ges_pkg::PDATA_W'(thr_q);
			default:                prdata = '0;
		endcase
	end

	// memory port and ALU request decode
	always_comb begin
		m_we = 1'b0;
		m_waddr = addr(i_q, k_q, c_cl);
		m_wdata = mrd_q;
		m_re = 1'b0;
		m_raddr = addr(i_q, k_q, c_cl);
		s_we = 1'b0;
		s_waddr = SW'(i_q);
		s_wdata = alu_rsp.result;
		s_re = 1'b0;
		s_raddr = SW'(j_q);
		alu_req = '{start: 1'b0, op: ges_pkg::ALU_MUL};
		alu_a = f_q;
		alu_b = aik_q;
		unique case (state_q)
			LOAD: begin
				m_we = in_acc && (lc_q < LW'(ges_pkg::CELLS));
				m_waddr = AW'(lc_q);
				m_wdata = element_ch.element;
			end
			PIV_RD: begin
				m_re = 1'b1;
				m_raddr = addr(j_q, CW'(i_q), c_cl);
			end
			SW_RD_A, EL_RD_I: m_re = 1'b1;
			SW_RD_B: begin
				m_re = 1'b1;
				m_raddr = addr(best_q, k_q, c_cl);
			end
			SW_WR_A: m_we = 1'b1;
			SW_WR_B: begin
				m_we = 1'b1;
				m_waddr = addr(best_q, k_q, c_cl);
				m_wdata = tmp_q;
			end
			EL_RD_F: begin
				m_re = 1'b1;
				m_raddr = addr(j_q, CW'(i_q), c_cl);
			end
			EL_DIV_START: begin
				alu_req = '{start: 1'b1, op: ges_pkg::ALU_DIV};
				alu_a = mrd_q;
				alu_b = piv_q;
			end
			EL_RD_J: begin
				m_re = 1'b1;
				m_raddr = addr(j_q, k_q, c_cl);
			end
			EL_MUL: begin
				alu_req = '{start: 1'b1, op: ges_pkg::ALU_MUL};
				alu_a = f_q;
				alu_b = aik_q;
			end
			EL_MUL_WAIT: begin
				m_we = alu_rsp.done;
				m_waddr = addr(j_q, k_q, c_cl);
				m_wdata = ges_pkg::sat_sub(ajk_q, alu_rsp.result);
			end
			BS_RD_S: begin
				m_re = 1'b1;
				m_raddr = addr(i_q, CW'(u_cl), c_cl);
			end
			BS_RD_J: begin
				m_re = 1'b1;
				m_raddr = addr(i_q, CW'(j_q), c_cl);
				s_re = 1'b1;
			end
			BS_MUL: begin
				alu_req = '{start: 1'b1, op: ges_pkg::ALU_MUL};
				alu_a = mrd_q;
				alu_b = srd_q;
			end
			BS_RD_D: begin
				m_re = 1'b1;
				m_raddr = addr(i_q, CW'(i_q), c_cl);
			end
			BS_DIV: begin
				alu_req = '{start: 1'b1, op: ges_pkg::ALU_DIV};
				alu_a = s_q;
				alu_b = mrd_q;
			end
			BS_DIV_WAIT: s_we = alu_rsp.done;
			EM_RD: begin
				s_re = 1'b1;
				s_raddr = SW'(e_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (m_we) mat_mem[m_waddr] <= m_wdata;
		if (m_re) mrd_q <= mat_mem[m_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_we) sol_mem[s_waddr] <= s_wdata;
		if (s_re) srd_q <= sol_mem[s_raddr];
	end

	ges_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.rsp    (alu_rsp)
	);

	// solve sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			lc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				LOAD: begin
					if (in_acc) begin
						if ((LW + 1)'(lc_q) + 1'b1 >= (LW + 1)'(total)) begin
							lc_q <= '0;
							state_q <= CHECK;
						end else begin
							lc_q <= lc_q + 1'b1;
						end
					end
				end
				CHECK: begin
					if (CW'(u_cl) + 1'b1 != c_cl) begin
						out_value_q <= '0;
						out_index_q <= '0;
						out_status_q <= ges_pkg::STATUS_SHAPE;
						out_last_q <= 1'b1;
						out_valid_q <= 1'b1;
						state_q <= EM_WAIT;
					end else begin
						i_q <= '0;
						state_q <= PIV_START;
					end
				end
				PIV_START: begin
					j_q <= i_q;
					state_q <= PIV_RD;
				end
				PIV_RD: state_q <= PIV_CMP;
				PIV_CMP: begin
					if (j_q == i_q || mrd_mag > bm_q) begin
						bm_q <= mrd_mag;
						best_q <= j_q;
						piv_q <= mrd_q;
					end
					if (j_q + 1'b1 < u_cl) begin
						j_q <= j_q + 1'b1;
						state_q <= PIV_RD;
					end else begin
						state_q <= PIV_DONE;
					end
				end
				PIV_DONE: begin
					if (64'(bm_q) < 64'(thr_q)) begin
						out_value_q <= '0;
						out_index_q <= '0;
						out_status_q <= ges_pkg::STATUS_SINGULAR;
						out_last_q <= 1'b1;
						out_valid_q <= 1'b1;
						state_q <= EM_WAIT;
					end else if (best_q != i_q) begin
						// columns left of the pivot are never read again
						k_q <= CW'(i_q);
						state_q <= SW_RD_A;
					end else begin
						state_q <= EL_START;
					end
				end
				SW_RD_A: state_q <= SW_RD_B;
				SW_RD_B: begin
					tmp_q <= mrd_q;
					state_q <= SW_WR_A;
				end
				SW_WR_A: state_q <= SW_WR_B;
				SW_WR_B: begin
					if (k_q + 1'b1 < c_cl) begin
						k_q <= k_q + 1'b1;
						state_q <= SW_RD_A;
					end else begin
						state_q <= EL_START;
					end
				end
				EL_START: begin
					j_q <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 < u_cl) ? EL_RD_F : NEXT_I;
				end
				EL_RD_F: state_q <= EL_DIV_START;
				EL_DIV_START: state_q <= EL_DIV_WAIT;
				EL_DIV_WAIT: begin
					if (alu_rsp.done) begin
						f_q <= alu_rsp.result;
						k_q <= CW'(i_q);
						state_q <= EL_RD_I;
					end
				end
				EL_RD_I: state_q <= EL_RD_J;
				EL_RD_J: begin
					aik_q <= mrd_q;
					state_q <= EL_MUL;
				end
				EL_MUL: begin
					ajk_q <= mrd_q;
					state_q <= EL_MUL_WAIT;
				end
				EL_MUL_WAIT: begin
					if (alu_rsp.done) begin
						if (k_q + 1'b1 < c_cl) begin
							k_q <= k_q + 1'b1;
							state_q <= EL_RD_I;
						end else if (j_q + 1'b1 < u_cl) begin
							j_q <= j_q + 1'b1;
							state_q <= EL_RD_F;
						end else begin
							state_q <= NEXT_I;
						end
					end
				end
				NEXT_I: begin
					if (i_q + 1'b1 < u_cl) begin
						i_q <= i_q + 1'b1;
						state_q <= PIV_START;
					end else begin
						i_q <= u_cl - 1'b1;
						state_q <= BS_RD_S;
					end
				end
				BS_RD_S: state_q <= BS_CAP_S;
				BS_CAP_S: begin
					s_q <= mrd_q;
					j_q <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 < u_cl) ? BS_RD_J : BS_RD_D;
				end
				BS_RD_J: state_q <= BS_MUL;
				BS_MUL: state_q <= BS_MUL_WAIT;
				BS_MUL_WAIT: begin
					if (alu_rsp.done) begin
						s_q <= ges_pkg::sat_sub(s_q, alu_rsp.result);
						if (j_q + 1'b1 < u_cl) begin
							j_q <= j_q + 1'b1;
							state_q <= BS_RD_J;
						end else begin
							state_q <= BS_RD_D;
						end
					end
				end
				BS_RD_D: state_q <= BS_DIV;
				BS_DIV: state_q <= BS_DIV_WAIT;
				BS_DIV_WAIT: begin
					if (alu_rsp.done) begin
						if (i_q == '0) begin
							e_q <= '0;
							state_q <= EM_RD;
						end else begin
							i_q <= i_q - 1'b1;
							state_q <= BS_RD_S;
						end
					end
				end
				EM_RD: state_q <= EM_CAP;
				EM_CAP: begin
					out_value_q <= srd_q;
					out_index_q <= ges_pkg::INDEX_W'(e_q);
					out_status_q <= ges_pkg::STATUS_OK;
					out_last_q <= (e_q + 1'b1 == u_cl);
					out_valid_q <= 1'b1;
					state_q <= EM_WAIT;
				end
				EM_WAIT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= LOAD;
						end else begin
							e_q <= e_q + 1'b1;
							state_q <= EM_RD;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.value = out_value_q;
	assign result_ch.index = out_index_q;
	assign result_ch.status = out_status_q;
	assign result_ch.last = out_last_q;

endmodule

// ----- sim/tb_gaussian_elimination_solver_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_elimination_solver_top: a table of directed runs,
// then random runs. Depends on ges_pkg, ges_element_if, ges_result_if and the design.
module tb_gaussian_elimination_solver_top;
	localparam int DATA_W = ges_pkg::DATA_W;
	localparam int FRAC_W = ges_pkg::FRAC_W;
	localparam int INDEX_W = ges_pkg::INDEX_W;
	localparam int UNK_W = ges_pkg::UNK_W;
	localparam int COLS_W = ges_pkg::COLS_W;
	localparam int THR_W = ges_pkg::THR_W;
	localparam int PADDR_W = ges_pkg::PADDR_W;
	localparam int PDATA_W = ges_pkg::PDATA_W;
	localparam int CELLS = ges_pkg::CELLS;
	localparam int MAX_UNKNOWNS = ges_pkg::MAX_UNKNOWNS;
	localparam int MAX_COLS = ges_pkg::MAX_COLS;

	localparam longint ONE = 64'sd1 << FRAC_W;
	localparam longint VMAX = (64'sd1 <<< (DATA_W - 1)) - 1;
	localparam longint VMIN = -VMAX - 1;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE = 40;

	typedef logic signed [DATA_W-1:0] fx_t;

	typedef struct {
		logic [INDEX_W-1:0] index;
		ges_pkg::status_t   status;
		logic               last;
		fx_t                value;
	} solution_t;

	// one directed run: register setting, its elements and, where obvious, the answer
	typedef struct {
		int               unk;
		int               cols;
		longint           thr;
		int               n;
		longint           e[6];
		bit               typed;
		longint           tv;
		ges_pkg::status_t ts;
	} run_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	ges_element_if el_if ();
	ges_result_if res_if ();

	gaussian_elimination_solver_top dut (
		.clk(clk), .arst_n(arst_n),
		.element_ch(el_if), .result_ch(res_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// register mirror, predictor state and scoreboard
	logic [UNK_W-1:0]  cfg_unknowns;
	logic [COLS_W-1:0] cfg_columns;
	logic [THR_W-1:0]  cfg_threshold;
	fx_t               matrix_mirror[CELLS];
	fx_t               solution_mirror[MAX_UNKNOWNS];
	int                loaded;
	bit                typed_pending;
	solution_t         typed_answer;
	solution_t         pending_solutions[$];

	int errors;
	int cycles;
	int elements_sent;
	int results_seen;
	int runs_done;
	int random_runs;
	bit hold_done;
	run_row_t directed[$];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------- fixed-point predictor ----------------
	function automatic logic [DATA_W-1:0] magnitude(fx_t v);
		return v < 0 ? DATA_W'(-v) : DATA_W'(v);
	endfunction

	function automatic fx_t saturate(bit neg, logic [127:0] m);
		logic [127:0] lim;
		lim = neg ? (128'd1 << (DATA_W - 1)) : ((128'd1 << (DATA_W - 1)) - 1);
		if (m > lim) m = lim;
		return neg ? fx_t'(-m[DATA_W-1:0]) : fx_t'(m[DATA_W-1:0]);
	endfunction

	function automatic fx_t fx_product(fx_t a, fx_t b);
		logic [127:0] p;
		p = 128'(magnitude(a)) * 128'(magnitude(b));
		return saturate((a < 0) != (b < 0), p >> FRAC_W);
	endfunction

	// a zero divisor saturates toward the sign of the dividend; 0/0 gives 0
	function automatic fx_t fx_quotient(fx_t a, fx_t b);
		logic [127:0] x, d;
		x = 128'(magnitude(a));
		d = 128'(magnitude(b));
		if (d == 0) return saturate(a < 0, x != 0 ? {128{1'b1}} : 128'd0);
		return saturate((a < 0) != (b < 0), (x << FRAC_W) / d);
	endfunction

	function automatic fx_t fx_difference(fx_t a, fx_t b);
		logic signed [DATA_W:0] d;
		d = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
		if (d > VMAX) return fx_t'(VMAX);
		if (d < VMIN) return fx_t'(VMIN);
		return fx_t'(d);
	endfunction

	function automatic int clamp_unknowns();
		return cfg_unknowns < 1 ? 1 : (cfg_unknowns > MAX_UNKNOWNS ? MAX_UNKNOWNS : cfg_unknowns);
	endfunction

	function automatic int clamp_columns();
		return cfg_columns < 1 ? 1 : (cfg_columns > MAX_COLS ? MAX_COLS : cfg_columns);
	endfunction

	function automatic void push_status(ges_pkg::status_t st);
		solution_t s;
		s.value = '0;
		s.index = '0;
		s.status = st;
		s.last = 1'b1;
		pending_solutions.push_back(s);
	endfunction

	// partial-pivot elimination plus back substitution on the mirrored matrix
	function automatic void solve_mirror();
		int u, c, best;
		logic [DATA_W-1:0] bm, m;
		fx_t t, f, acc;
		solution_t s;
		u = clamp_unknowns();
		c = clamp_columns();
		if (u + 1 != c) begin
			push_status(ges_pkg::STATUS_SHAPE);
			return;
		end
		for (int i = 0; i < u; i++) begin
			best = i;
			bm = magnitude(matrix_mirror[i*c+i]);
			for (int j = i + 1; j < u; j++) begin
				m = magnitude(matrix_mirror[j*c+i]);
				if (m > bm) begin
					bm = m;
					best = j;
				end
			end
			if (best != i)
				for (int k = 0; k < c; k++) begin
					t = matrix_mirror[i*c+k];
					matrix_mirror[i*c+k] = matrix_mirror[best*c+k];
					matrix_mirror[best*c+k] = t;
				end
			if (magnitude(matrix_mirror[i*c+i]) < cfg_threshold) begin
				push_status(ges_pkg::STATUS_SINGULAR);
				return;
			end
			for (int j = i + 1; j < u; j++) begin
				f = fx_quotient(matrix_mirror[j*c+i], matrix_mirror[i*c+i]);
				for (int k = i; k < c; k++)
					matrix_mirror[j*c+k] = fx_difference(matrix_mirror[j*c+k],
						fx_product(f, matrix_mirror[i*c+k]));
			end
		end
		for (int i = u - 1; i >= 0; i--) begin
			acc = matrix_mirror[i*c+u];
			for (int j = i + 1; j < u; j++)
				acc = fx_difference(acc, fx_product(matrix_mirror[i*c+j], solution_mirror[j]));
			solution_mirror[i] = fx_quotient(acc, matrix_mirror[i*c+i]);
		end
		for (int i = 0; i < u; i++) begin
			s.value = solution_mirror[i];
			s.index = INDEX_W'(i);
			s.status = ges_pkg::STATUS_OK;
			s.last = (i + 1 == u);
			pending_solutions.push_back(s);
		end
	endfunction

	// ---------------- monitor: both channels sampled at the rising edge ----------------
	always @(posedge clk) begin
		solution_t want;
		if (arst_n && el_if.valid && el_if.ready) begin
			if (loaded < CELLS) matrix_mirror[loaded] = el_if.element;
			loaded++;
			elements_sent++;
			if (loaded >= clamp_unknowns() * clamp_columns()) begin
				loaded = 0;
				runs_done++;
				if (typed_pending) pending_solutions.push_back(typed_answer);
				else solve_mirror();
			end
		end
		if (arst_n && res_if.valid && res_if.ready) begin
			results_seen++;
			if (pending_solutions.size() == 0) begin
				$error("result transaction with nothing expected: value %0d status %0d",
					res_if.value, res_if.status);
				errors++;
			end else begin
				want = pending_solutions.pop_front();
				if (res_if.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, res_if.value);
					errors++;
				end
				if (res_if.index !== want.index) begin
					$error("index: expected %0d, got %0d", want.index, res_if.index);
					errors++;
				end
				if (res_if.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_if.status);
					errors++;
				end
				if (res_if.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, res_if.last);
					errors++;
				end
			end
		end
	end

	// ---------------- receiver: random stalls plus one long hold-off ----------------
	initial begin
		int gap;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			// once results flow, stop taking them for a long stretch so the block backs up
			if (!hold_done && results_seen >= 6) begin
				hold_done = 1;
				@(negedge clk);
				res_if.ready = 1'b0;
				repeat (400) @(negedge clk);
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			repeat (gap) begin
				@(negedge clk);
				res_if.ready = 1'b0;
			end
			@(negedge clk);
			res_if.ready = 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	// ---------------- sender side ----------------
	task automatic reg_write(ges_pkg::reg_idx_t r, logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = PADDR_W'(4 * int'(r));
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (r)
			ges_pkg::REG_UNKNOWNS:  cfg_unknowns = data[UNK_W-1:0];
			ges_pkg::REG_COLUMNS:   cfg_columns = data[COLS_W-1:0];
			ges_pkg::REG_THRESHOLD: cfg_threshold = data[THR_W-1:0];
			default: ;
		endcase
	endtask

	// the sender holds still until every expected result is in, then lets the block settle
	task automatic drain();
		while (pending_solutions.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// an unchanged setting needs no write, so the next run queues up behind the current one
	task automatic configure(int u, int c, longint thr);
		if (cfg_unknowns == UNK_W'(u) && cfg_columns == COLS_W'(c) &&
				cfg_threshold == THR_W'(thr))
			return;
		drain();
		reg_write(ges_pkg::REG_UNKNOWNS, PDATA_W'(u));
		reg_write(ges_pkg::REG_COLUMNS, PDATA_W'(c));
		reg_write(ges_pkg::REG_THRESHOLD, PDATA_W'(thr));
	endtask

	task automatic send_element(fx_t e, bit bursty);
		int gap;
		gap = bursty ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			@(negedge clk);
			el_if.valid = 1'b0;
		end
		@(negedge clk);
		el_if.valid = 1'b1;
		el_if.element = e;
		do @(posedge clk); while (!el_if.ready);
	endtask

	task automatic add_row(int u, int c, longint thr, int n, longint e0, longint e1,
			longint e2 = 0, longint e3 = 0, longint e4 = 0, longint e5 = 0,
			bit typed = 0, longint tv = 0, ges_pkg::status_t ts = ges_pkg::STATUS_OK);
		run_row_t r;
		r.unk = u; r.cols = c; r.thr = thr; r.n = n;
		r.e[0] = e0; r.e[1] = e1; r.e[2] = e2; r.e[3] = e3; r.e[4] = e4; r.e[5] = e5;
		r.typed = typed; r.tv = tv; r.ts = ts;
		directed.push_back(r);
	endtask

	function automatic fx_t random_full();
		return fx_t'({$urandom, $urandom});
	endfunction

	function automatic fx_t random_signed(longint span);
		longint v;
		v = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF) % (span + 1);
		return fx_t'($urandom_range(0, 1) ? -v : v);
	endfunction

	initial begin
		solution_t ans;
		int u, uc, cc, thr_pick, bursty;
		longint thr;
		bit noisy;
		fx_t e;

		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		el_if.valid = 1'b0;
		el_if.element = '0;
		cfg_unknowns = 4'd8; cfg_columns = 4'd9; cfg_threshold = 25'd1;
		loaded = 0; typed_pending = 0; errors = 0; cycles = 0;
		elements_sent = 0; results_seen = 0; runs_done = 0; random_runs = 0; hold_done = 0;
		for (int i = 0; i < CELLS; i++) matrix_mirror[i] = '0;
		for (int i = 0; i < MAX_UNKNOWNS; i++) solution_mirror[i] = '0;

		// directed runs: plain 1x1, shape mismatch, singular, zero divisors,
		// extreme operands, runs queued behind a held result, a row swap,
		// a threshold of 1.0, clamped unknowns
		add_row(1, 2, 1, 2, ONE, 2 * ONE, .typed(1), .tv(2 * ONE), .ts(ges_pkg::STATUS_OK));
		add_row(1, 1, 1, 1, 3 * ONE, 0, .typed(1), .ts(ges_pkg::STATUS_SHAPE));
		add_row(1, 2, 1, 2, 0, 5 * ONE, .typed(1), .ts(ges_pkg::STATUS_SINGULAR));
		add_row(1, 2, 0, 2, 0, -5 * ONE);
		add_row(1, 2, 0, 2, 0, 0);
		add_row(1, 2, 1, 2, VMAX, VMIN);
		add_row(1, 2, 1, 2, VMIN, VMAX);
		add_row(1, 2, 1, 2, -3 * ONE, 6 * ONE);
		add_row(2, 3, 1, 6, ONE, ONE, 3 * ONE, 2 * ONE, ONE, 4 * ONE);
		add_row(1, 2, 16777216, 2, ONE / 2, ONE, .typed(1), .ts(ges_pkg::STATUS_SINGULAR));
		add_row(0, 2, 1, 2, 2 * ONE, ONE);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			configure(directed[i].unk, directed[i].cols, directed[i].thr);
			typed_pending = directed[i].typed;
			ans.value = fx_t'(directed[i].tv);
			ans.index = '0;
			ans.status = directed[i].ts;
			ans.last = 1'b1;
			typed_answer = ans;
			for (int k = 0; k < directed[i].n; k++)
				send_element(fx_t'(directed[i].e[k]), 0);
			@(negedge clk);
			el_if.valid = 1'b0;
		end
		drain();
		typed_pending = 0;

		// random runs: mostly well-conditioned small systems, some noise and broken shapes
		while (elements_sent < 100) begin
			uc = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 8);
			if ($urandom_range(0, 19) == 0) uc = $urandom_range(0, 15);
			cc = uc + 1;
			if ($urandom_range(0, 9) == 0) cc = $urandom_range(0, 15);
			thr_pick = $urandom_range(0, 9);
			thr = thr_pick < 6 ? 1 : (thr_pick == 6 ? 0 :
				(thr_pick == 7 ? 16777216 : $urandom_range(0, 16777216)));
			configure(uc, cc, thr);
			noisy = ($urandom_range(0, 5) == 0);
			bursty = $urandom_range(0, 2) == 0;
			u = clamp_unknowns();
			for (int k = 0; k < clamp_unknowns() * clamp_columns(); k++) begin
				if (noisy) e = random_full();
				else if (k % clamp_columns() == u) e = random_signed(8 * ONE);
				else if (k % clamp_columns() == k / clamp_columns())
					e = fx_t'((u + 2) * ONE) + random_signed(ONE);
				else e = random_signed(ONE);
				send_element(e, bursty);
			end
			@(negedge clk);
			el_if.valid = 1'b0;
			random_runs++;
		end

		drain();
		repeat (100) @(posedge clk);
		$display("Covered %0d solves (%0d random) from %0d matrix elements, %0d result transactions.",
			runs_done, random_runs, elements_sent, results_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
